### rtl/core/glnw_pkg.sv
`timescale 1ns / 1ps

package glnw_pkg;

  localparam int unsigned MAX_POINTS    = 128;
  localparam int unsigned FRACTION_BITS = 30;
  localparam int unsigned MAX_EXACT     = 2 * MAX_POINTS - 3;
  localparam int unsigned SEED_TERMS    = 14;

  // product / dividend widths for the shared unit
  localparam int unsigned PROD_BITS   = 128;
  localparam int unsigned NARROW_BITS = 72;

  typedef logic signed [63:0] q_t;

  localparam q_t SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam q_t SAT_MIN = 64'sh8000_0000_0000_0000;
  localparam q_t QONE    = 64'sd1 <<< FRACTION_BITS;
  localparam q_t QTWO    = 64'sd2 <<< FRACTION_BITS;
  // pi with 60 fraction bits, rounded to FRACTION_BITS
  localparam logic [63:0] PI_Q60 = 64'h3243_F6A8_885A_308D;
  localparam q_t PI_Q =
    q_t'((PI_Q60 + (64'd1 << (59 - FRACTION_BITS))) >> (60 - FRACTION_BITS));

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_RANGE   = 3'd1;
  localparam logic [2:0] ST_INDEX   = 3'd2;
  localparam logic [2:0] ST_NOCONV  = 3'd3;
  localparam logic [2:0] ST_BADROOT = 3'd4;

  // configuration register indexes
  localparam logic CFG_ITER_LIMIT = 1'b0;
  localparam logic CFG_TOLERANCE  = 1'b1;

  typedef struct packed {
    logic [7:0] exactness;
    logic [6:0] pt_idx;
  } glnw_in_t;

  typedef struct packed {
    logic signed [31:0] node;
    logic [30:0]        weight;
    logic [7:0]         point_count;
    logic [7:0]         achieved_exactness;
    logic [2:0]         status;
  } glnw_out_t;

  typedef enum logic [1:0] {
    MD_SHIFT,
    MD_ONE,
    MD_DIV
  } md_mode_e;

  typedef struct packed {
    logic     start;
    md_mode_e mode;
    logic     wide;
  } md_req_t;

  typedef enum logic [2:0] {
    MS_IDLE,
    MS_MUL,
    MS_ACC,
    MS_PREP,
    MS_DIV,
    MS_RND,
    MS_FIN,
    MS_DONE
  } md_state_e;

  typedef enum logic [5:0] {
    S_IDLE, S_DECODE, S_EP, S_EP_R, S_TH, S_TH_R, S_T2, S_T2_R,
    S_CS1, S_CS1_R, S_CS2, S_CS2_R, S_IT_CHK, S_LP_INIT,
    S_LP1, S_LP1_R, S_LP2, S_LP2_R, S_LP3, S_LP3_R,
    S_RS, S_RS_R, S_DER, S_DER_R, S_CR, S_CR_R, S_CHK,
    S_DEN1, S_DEN1_R, S_DEN2, S_DEN2_R, S_W, S_W_R, S_WAIT, S_OUT
  } seq_state_e;

  function automatic q_t sat_add(q_t a, q_t b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? SAT_MIN : SAT_MAX;
    end
    return q_t'(s[63:0]);
  endfunction

  function automatic q_t sat_neg(q_t a);
    return (a == SAT_MIN) ? SAT_MAX : -a;
  endfunction

  function automatic q_t sat_sub(q_t a, q_t b);
    return sat_add(a, sat_neg(b));
  endfunction

  function automatic logic [63:0] mag64(q_t a);
    return a[63] ? (64'd0 - 64'(a)) : 64'(a);
  endfunction

endpackage

### rtl/core/glnw_muldiv.sv
`timescale 1ns / 1ps

// round(a*b/s), ties away from zero, saturated to 64 bits; s is c, 2^30 or 1.
// 64x64 product from four 32x32 partials, then shift, pass or bit-serial divide.
module glnw_muldiv (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  glnw_pkg::md_req_t     req_i,
  input  glnw_pkg::q_t          a_i,
  input  glnw_pkg::q_t          b_i,
  input  glnw_pkg::q_t          c_i,
  output glnw_pkg::q_t          res_o,
  output logic                  done_o
);

  glnw_pkg::md_state_e state_q, state_d;

  logic [63:0]  am_q, bm_q, dm_q;
  logic         neg_q;
  glnw_pkg::md_mode_e mode_q;
  logic         wide_q;
  logic [1:0]   part_q;
  logic [63:0]  pp_q;
  logic [127:0] acc_q;
  logic [127:0] quo_q;
  logic [63:0]  rem_q;
  logic [6:0]   cnt_q;
  logic         rnd_q;
  glnw_pkg::q_t res_q;

  logic [31:0]  pa, pb;
  logic [64:0]  trial;
  logic         ge;
  logic [127:0] qi;
  logic         big;

  always_comb begin
    pa    = part_q[1] ? am_q[63:32] : am_q[31:0];
    pb    = part_q[0] ? bm_q[63:32] : bm_q[31:0];
    trial = {rem_q, quo_q[127]};
    ge    = trial >= {1'b0, dm_q};
    qi    = quo_q + {127'd0, rnd_q};
    big   = |qi[127:63];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      glnw_pkg::MS_IDLE: begin
        if (req_i.start) state_d = glnw_pkg::MS_MUL;
      end
      glnw_pkg::MS_MUL:  state_d = glnw_pkg::MS_ACC;
      glnw_pkg::MS_ACC:  state_d = (part_q == 2'd3) ? glnw_pkg::MS_PREP : glnw_pkg::MS_MUL;
      glnw_pkg::MS_PREP: begin
        state_d = (mode_q == glnw_pkg::MD_DIV && dm_q != 64'd0) ?
                  glnw_pkg::MS_DIV : glnw_pkg::MS_FIN;
      end
      glnw_pkg::MS_DIV:  if (cnt_q == 7'd0) state_d = glnw_pkg::MS_RND;
      glnw_pkg::MS_RND:  state_d = glnw_pkg::MS_FIN;
      glnw_pkg::MS_FIN:  state_d = glnw_pkg::MS_DONE;
      glnw_pkg::MS_DONE: state_d = glnw_pkg::MS_IDLE;
      default:           state_d = glnw_pkg::MS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    done_o = (state_q == glnw_pkg::MS_DONE);
    res_o  = res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= glnw_pkg::MS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      glnw_pkg::MS_IDLE: begin
        if (req_i.start) begin
          am_q   <= glnw_pkg::mag64(a_i);
          bm_q   <= glnw_pkg::mag64(b_i);
          dm_q   <= glnw_pkg::mag64(c_i);
          neg_q  <= a_i[63] ^ b_i[63] ^ c_i[63];
          mode_q <= req_i.mode;
          wide_q <= req_i.wide;
          part_q <= 2'd0;
          acc_q  <= 128'd0;
        end
      end
      glnw_pkg::MS_MUL: begin
        pp_q <= {32'd0, pa} * {32'd0, pb};
      end
      glnw_pkg::MS_ACC: begin
        case (part_q)
          2'd0:    acc_q <= acc_q + {64'd0, pp_q};
          2'd3:    acc_q <= acc_q + {pp_q, 64'd0};
          default: acc_q <= acc_q + {32'd0, pp_q, 32'd0};
        endcase
        part_q <= part_q + 2'd1;
      end
      glnw_pkg::MS_PREP: begin
        rem_q <= 64'd0;
        case (mode_q)
          glnw_pkg::MD_SHIFT: begin
            quo_q <= acc_q >> glnw_pkg::FRACTION_BITS;
            rnd_q <= acc_q[glnw_pkg::FRACTION_BITS-1];
          end
          glnw_pkg::MD_ONE: begin
            quo_q <= acc_q;
            rnd_q <= 1'b0;
          end
          default: begin
            // zero divisor falls through to FIN with a zero quotient
            if (dm_q == 64'd0) begin
              quo_q <= 128'd0;
            end else if (wide_q) begin
              quo_q <= acc_q;
            end else begin
              quo_q <= acc_q << (glnw_pkg::PROD_BITS - glnw_pkg::NARROW_BITS);
            end
            rnd_q <= 1'b0;
            cnt_q <= wide_q ? 7'(glnw_pkg::PROD_BITS - 1) : 7'(glnw_pkg::NARROW_BITS - 1);
          end
        endcase
      end
      glnw_pkg::MS_DIV: begin
        rem_q <= ge ? 64'(trial - {1'b0, dm_q}) : trial[63:0];
        quo_q <= {quo_q[126:0], ge};
        cnt_q <= cnt_q - 7'd1;
      end
      glnw_pkg::MS_RND: begin
        rnd_q <= rem_q >= (dm_q - rem_q);
      end
      glnw_pkg::MS_FIN: begin
        if (neg_q) begin
          res_q <= big ? glnw_pkg::SAT_MIN : -glnw_pkg::q_t'(qi[63:0]);
        end else begin
          res_q <= big ? glnw_pkg::SAT_MAX : glnw_pkg::q_t'(qi[63:0]);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/core/gauss_lobatto_node_weight.sv
`timescale 1ns / 1ps
// Sequence: an endpoint needs one divide; an interior point computes a Taylor seed, then
//   runs Newton steps, plus one recheck pass and the weight.
// Throughput: one beat at a time; the shared mul/div unit (four-partial product, bit-serial
//   divide of a 72- or 128-bit dividend) sets the pace. The next beat is taken while a result waits.
// Reset: rst_ni asynchronous active low; iteration_limit 100, tolerance_lsbs 16, idle.
module gauss_lobatto_node_weight (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  glnw_pkg::glnw_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output glnw_pkg::glnw_out_t  out_data_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [7:0]           cfg_wdata_i
);

  // configuration
  logic [6:0] limit_q;
  logic [7:0] tol_q;

  glnw_pkg::seq_state_e state_q, state_d, ret_q, ret_d;

  // shared unit request
  glnw_pkg::md_req_t md_req;
  glnw_pkg::q_t      md_a, md_b, md_c, md_res;
  logic              md_done;

  // beat decode
  logic [7:0] e_q, n_q, pc_q, ae_q;
  logic [6:0] idx_q, h_q, k_q;
  logic       left_q, center_q, final_q;
  logic [7:0] it_q;
  logic [2:0] st_q;

  // working values, Q.FRACTION_BITS
  glnw_pkg::q_t x_q, v_q, p_q, ta_q, a1_q, rs_q, t2_q, term_q, sum_q, mres_q;
  glnw_pkg::q_t node_q, weight_q;

  glnw_pkg::glnw_out_t out_q;
  logic                out_valid_q;

  // derived terms
  logic [7:0]   m8, h8;
  logic [15:0]  kk2, fact16, nn1;
  glnw_pkg::q_t kk, lp_nx, cs_nt, cs_ns, root_step, rstep_raw, chk_x;
  logic         corr_ok, it_over, chk_bad, k_last, seed_last;
  logic         e_bad, idx_bad, idx_end, left_c, center_c;
  logic         out_free;

  always_comb begin
    m8        = n_q - 8'd1;
    kk        = glnw_pkg::q_t'({57'd0, k_q});
    kk2       = {8'd0, k_q, 1'b0};
    fact16    = (kk2 - 16'd1) * kk2;
    nn1       = {8'd0, n_q} * {8'd0, m8};
    lp_nx     = glnw_pkg::sat_sub(a1_q, mres_q);
    cs_nt     = glnw_pkg::sat_neg(mres_q);
    cs_ns     = glnw_pkg::sat_add(sum_q, cs_nt);
    rstep_raw = glnw_pkg::sat_sub(x_q, mres_q);
    if (rstep_raw > glnw_pkg::QTWO) begin
      root_step = glnw_pkg::QTWO;
    end else if (rstep_raw < -glnw_pkg::QTWO) begin
      root_step = -glnw_pkg::QTWO;
    end else begin
      root_step = rstep_raw;
    end
    corr_ok   = glnw_pkg::mag64(mres_q) <= {56'd0, tol_q};
    it_over   = it_q > {1'b0, limit_q};
    chk_x     = center_q ? '0 : x_q;
    chk_bad   = chk_x[63] || (chk_x >= glnw_pkg::QONE) || (!center_q && chk_x == '0);
    k_last    = ({1'b0, k_q} == m8);
    seed_last = (k_q == 7'(glnw_pkg::SEED_TERMS));
    e_bad     = e_q > 8'(glnw_pkg::MAX_EXACT);
    idx_bad   = {1'b0, idx_q} >= n_q;
    idx_end   = (idx_q == 7'd0) || ({1'b0, idx_q} == m8);
    // mirror: left half counts from the left end, right half from the right end
    left_c    = ({1'b0, idx_q} - 8'd1) < (m8 >> 1);
    h8        = left_c ? ({1'b0, idx_q} - 8'd1) : (n_q - 8'd2 - {1'b0, idx_q});
    center_c  = ({h8[6:0], 1'b0} == (n_q - 8'd3));
    out_free  = !out_valid_q || !out_stall_i;
  end

  // next state
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    case (state_q)
      glnw_pkg::S_IDLE:   if (in_valid_i) state_d = glnw_pkg::S_DECODE;
      glnw_pkg::S_DECODE: begin
        if (e_bad || idx_bad) state_d = glnw_pkg::S_OUT;
        else if (idx_end)     state_d = glnw_pkg::S_EP;
        else                  state_d = glnw_pkg::S_TH;
      end
      glnw_pkg::S_EP:   begin state_d = glnw_pkg::S_WAIT; ret_d = glnw_pkg::S_EP_R;   end
      glnw_pkg::S_TH:   begin state_d = glnw_pkg::S_WAIT; ret_d = glnw_pkg::S_TH_R;   end
      glnw_pkg::S_T2:   begin state_d = glnw_pkg::S_WAIT; ret_d = glnw_pkg::S_T2_R;   end
      glnw_pkg::S_CS1:  begin state_d = glnw_pkg::S_WAIT; ret_d = glnw_pkg::S_CS1_R;  end
      glnw_pkg::S_CS2:  begin state_d = glnw_pkg::S_WAIT; ret_d = glnw_pkg::S_CS2_R;  end
      glnw_pkg::S_LP1:  begin state_d = glnw_pkg::S_WAIT; ret_d = glnw_pkg::S_LP1_R;  end
      glnw_pkg::S_LP2:  begin state_d = glnw_pkg::S_WAIT; ret_d = glnw_pkg::S_LP2_R;  end
      glnw_pkg::S_LP3:  begin state_d = glnw_pkg::S_WAIT; ret_d = glnw_pkg::S_LP3_R;  end
      glnw_pkg::S_RS:   begin state_d = glnw_pkg::S_WAIT; ret_d = glnw_pkg::S_RS_R;   end
      glnw_pkg::S_DER:  begin state_d = glnw_pkg::S_WAIT; ret_d = glnw_pkg::S_DER_R;  end
      glnw_pkg::S_CR:   begin state_d = glnw_pkg::S_WAIT; ret_d = glnw_pkg::S_CR_R;   end
      glnw_pkg::S_DEN1: begin state_d = glnw_pkg::S_WAIT; ret_d = glnw_pkg::S_DEN1_R; end
      glnw_pkg::S_DEN2: begin state_d = glnw_pkg::S_WAIT; ret_d = glnw_pkg::S_DEN2_R; end
      glnw_pkg::S_W:    begin state_d = glnw_pkg::S_WAIT; ret_d = glnw_pkg::S_W_R;    end
      glnw_pkg::S_WAIT: if (md_done) state_d = ret_q;
      glnw_pkg::S_EP_R: state_d = glnw_pkg::S_OUT;
      glnw_pkg::S_TH_R: state_d = glnw_pkg::S_T2;
      glnw_pkg::S_T2_R: state_d = glnw_pkg::S_CS1;
      glnw_pkg::S_CS1_R: state_d = glnw_pkg::S_CS2;
      glnw_pkg::S_CS2_R: state_d = seed_last ? glnw_pkg::S_IT_CHK : glnw_pkg::S_CS1;
      glnw_pkg::S_IT_CHK: state_d = it_over ? glnw_pkg::S_OUT : glnw_pkg::S_LP_INIT;
      glnw_pkg::S_LP_INIT: state_d = glnw_pkg::S_LP1;
      glnw_pkg::S_LP1_R: state_d = glnw_pkg::S_LP2;
      glnw_pkg::S_LP2_R: state_d = glnw_pkg::S_LP3;
      glnw_pkg::S_LP3_R: state_d = k_last ? glnw_pkg::S_RS : glnw_pkg::S_LP1;
      glnw_pkg::S_RS_R:  state_d = glnw_pkg::S_DER;
      glnw_pkg::S_DER_R: state_d = (mres_q == '0) ? glnw_pkg::S_OUT : glnw_pkg::S_CR;
      glnw_pkg::S_CR_R: begin
        if (!final_q) state_d = corr_ok ? glnw_pkg::S_CHK : glnw_pkg::S_IT_CHK;
        else          state_d = corr_ok ? glnw_pkg::S_DEN1 : glnw_pkg::S_OUT;
      end
      glnw_pkg::S_CHK:    state_d = chk_bad ? glnw_pkg::S_OUT : glnw_pkg::S_LP_INIT;
      glnw_pkg::S_DEN1_R: state_d = glnw_pkg::S_DEN2;
      glnw_pkg::S_DEN2_R: begin
        state_d = (mres_q[63] || mres_q == '0) ? glnw_pkg::S_OUT : glnw_pkg::S_W;
      end
      glnw_pkg::S_W_R:  state_d = glnw_pkg::S_OUT;
      glnw_pkg::S_OUT:  if (out_free) state_d = glnw_pkg::S_IDLE;
      default:          state_d = glnw_pkg::S_IDLE;
    endcase
  end

  // outputs: shared unit operands and input stall
  always_comb begin
    in_stall_o   = (state_q != glnw_pkg::S_IDLE);
    md_req.start = 1'b0;
    md_req.mode  = glnw_pkg::MD_SHIFT;
    md_req.wide  = 1'b1;
    md_a         = x_q;
    md_b         = v_q;
    md_c         = glnw_pkg::QONE;
    case (state_q)
      glnw_pkg::S_EP: begin
        md_req.start = 1'b1;
        md_req.mode  = glnw_pkg::MD_DIV;
        md_a         = glnw_pkg::QTWO;
        md_b         = 64'sd1;
        md_c         = glnw_pkg::q_t'({48'd0, nn1});
      end
      glnw_pkg::S_TH: begin
        md_req.start = 1'b1;
        md_req.mode  = glnw_pkg::MD_DIV;
        md_a         = glnw_pkg::PI_Q;
        md_b         = glnw_pkg::q_t'({56'd0, ({1'b0, h_q} + 8'd1)});
        md_c         = glnw_pkg::q_t'({56'd0, m8});
      end
      glnw_pkg::S_T2: begin
        md_req.start = 1'b1;
        md_a         = ta_q;
        md_b         = ta_q;
      end
      glnw_pkg::S_CS1: begin
        md_req.start = 1'b1;
        md_a         = term_q;
        md_b         = t2_q;
      end
      glnw_pkg::S_CS2: begin
        md_req.start = 1'b1;
        md_req.mode  = glnw_pkg::MD_DIV;
        md_a         = ta_q;
        md_b         = 64'sd1;
        md_c         = glnw_pkg::q_t'({48'd0, fact16});
      end
      glnw_pkg::S_LP1, glnw_pkg::S_RS: begin
        md_req.start = 1'b1;
      end
      glnw_pkg::S_LP2: begin
        md_req.start = 1'b1;
        md_req.mode  = glnw_pkg::MD_DIV;
        md_req.wide  = 1'b0;
        md_a         = (kk <<< 1) - 64'sd1;
        md_b         = ta_q;
        md_c         = kk;
      end
      glnw_pkg::S_LP3: begin
        md_req.start = 1'b1;
        md_req.mode  = glnw_pkg::MD_DIV;
        md_req.wide  = 1'b0;
        md_a         = kk - 64'sd1;
        md_b         = p_q;
        md_c         = kk;
      end
      glnw_pkg::S_DER: begin
        md_req.start = 1'b1;
        md_req.mode  = glnw_pkg::MD_ONE;
        md_a         = v_q;
        md_b         = glnw_pkg::q_t'({56'd0, n_q});
        md_c         = 64'sd1;
      end
      glnw_pkg::S_CR: begin
        md_req.start = 1'b1;
        md_req.mode  = glnw_pkg::MD_DIV;
        md_a         = rs_q;
        md_b         = glnw_pkg::QONE;
        md_c         = ta_q;
      end
      glnw_pkg::S_DEN1: begin
        md_req.start = 1'b1;
        md_a         = v_q;
        md_b         = v_q;
      end
      glnw_pkg::S_DEN2: begin
        md_req.start = 1'b1;
        md_req.mode  = glnw_pkg::MD_ONE;
        md_a         = ta_q;
        md_b         = glnw_pkg::q_t'({48'd0, nn1});
        md_c         = 64'sd1;
      end
      glnw_pkg::S_W: begin
        md_req.start = 1'b1;
        md_req.mode  = glnw_pkg::MD_DIV;
        md_a         = glnw_pkg::QTWO;
        md_b         = glnw_pkg::QONE;
        md_c         = ta_q;
      end
      default: begin
      end
    endcase
  end

  glnw_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .a_i    (md_a),
    .b_i    (md_b),
    .c_i    (md_c),
    .res_o  (md_res),
    .done_o (md_done)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= glnw_pkg::S_IDLE;
      ret_q       <= glnw_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      limit_q     <= 7'd100;
      tol_q       <= 8'd16;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          glnw_pkg::CFG_ITER_LIMIT: limit_q <= cfg_wdata_i[6:0];
          glnw_pkg::CFG_TOLERANCE:  tol_q   <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      if (state_q == glnw_pkg::S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath; node and weight are cleared at decode and stay zero on every failure path
  always_ff @(posedge clk_i) begin
    case (state_q)
      glnw_pkg::S_IDLE: begin
        if (in_valid_i) begin
          e_q   <= in_data_i.exactness;
          idx_q <= in_data_i.pt_idx;
          n_q   <= {1'b0, in_data_i.exactness[7:1]} + 8'd2;
        end
      end
      glnw_pkg::S_DECODE: begin
        left_q   <= left_c;
        h_q      <= h8[6:0];
        center_q <= center_c;
        final_q  <= 1'b0;
        node_q   <= '0;
        weight_q <= '0;
        pc_q     <= n_q;
        ae_q     <= {n_q[6:0], 1'b0} - 8'd3;
        st_q     <= glnw_pkg::ST_OK;
        if (e_bad) begin
          st_q <= glnw_pkg::ST_RANGE;
          pc_q <= 8'd0;
          ae_q <= 8'd0;
        end else if (idx_bad) begin
          st_q <= glnw_pkg::ST_INDEX;
        end
      end
      glnw_pkg::S_WAIT: if (md_done) mres_q <= md_res;
      glnw_pkg::S_EP_R: begin
        weight_q <= mres_q;
        node_q   <= (idx_q == 7'd0) ? -glnw_pkg::QONE : glnw_pkg::QONE;
      end
      glnw_pkg::S_TH_R: ta_q <= mres_q;
      glnw_pkg::S_T2_R: begin
        t2_q   <= mres_q;
        term_q <= glnw_pkg::QONE;
        sum_q  <= glnw_pkg::QONE;
        k_q    <= 7'd1;
      end
      glnw_pkg::S_CS1_R: ta_q <= mres_q;
      glnw_pkg::S_CS2_R: begin
        term_q <= cs_nt;
        sum_q  <= cs_ns;
        k_q    <= k_q + 7'd1;
        if (seed_last) begin
          x_q  <= cs_ns;
          it_q <= 8'd1;
        end
      end
      glnw_pkg::S_IT_CHK: if (it_over) st_q <= glnw_pkg::ST_NOCONV;
      glnw_pkg::S_LP_INIT: begin
        p_q <= glnw_pkg::QONE;
        v_q <= x_q;
        k_q <= 7'd2;
      end
      glnw_pkg::S_LP1_R: ta_q <= mres_q;
      glnw_pkg::S_LP2_R: a1_q <= mres_q;
      glnw_pkg::S_LP3_R: begin
        p_q <= v_q;
        v_q <= lp_nx;
        k_q <= k_q + 7'd1;
      end
      glnw_pkg::S_RS_R: rs_q <= glnw_pkg::sat_sub(mres_q, p_q);
      glnw_pkg::S_DER_R: begin
        ta_q <= mres_q;
        if (mres_q == '0) st_q <= final_q ? glnw_pkg::ST_BADROOT : glnw_pkg::ST_NOCONV;
      end
      glnw_pkg::S_CR_R: begin
        if (!final_q) begin
          x_q  <= root_step;
          it_q <= it_q + 8'd1;
        end else if (!corr_ok) begin
          st_q <= glnw_pkg::ST_BADROOT;
        end
      end
      glnw_pkg::S_CHK: begin
        x_q     <= chk_x;
        final_q <= 1'b1;
        if (chk_bad) st_q <= glnw_pkg::ST_BADROOT;
      end
      glnw_pkg::S_DEN1_R: ta_q <= mres_q;
      glnw_pkg::S_DEN2_R: begin
        ta_q <= mres_q;
        if (mres_q[63] || mres_q == '0) st_q <= glnw_pkg::ST_BADROOT;
      end
      glnw_pkg::S_W_R: begin
        if (mres_q[63] || mres_q == '0) begin
          st_q <= glnw_pkg::ST_BADROOT;
        end else begin
          weight_q <= (mres_q > glnw_pkg::QONE) ? glnw_pkg::QONE : mres_q;
          node_q   <= left_q ? -x_q : x_q;
        end
      end
      glnw_pkg::S_OUT: begin
        if (out_free) begin
          out_q.node               <= node_q[31:0];
          out_q.weight             <= weight_q[30:0];
          out_q.point_count        <= pc_q;
          out_q.achieved_exactness <= ae_q;
          out_q.status             <= st_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != glnw_pkg::ST_OK |->
      out_data_o.node == 32'sd0 && out_data_o.weight == 31'd0)
    else $error("failed result carries a node or weight");

  a_range_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == glnw_pkg::ST_RANGE |->
      out_data_o.point_count == 8'd0 && out_data_o.achieved_exactness == 8'd0)
    else $error("range error with nonzero point count");

  a_start_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_req.start |=> state_q == glnw_pkg::S_WAIT)
    else $error("shared unit started without waiting");

  a_ok_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == glnw_pkg::ST_OK |->
      out_data_o.weight != 31'd0 && out_data_o.weight <= 31'(glnw_pkg::QONE))
    else $error("good result with weight out of range");

endmodule

### bench/tb_gauss_lobatto_node_weight.sv
`timescale 1ns / 1ps

module tb_gauss_lobatto_node_weight;

  // Q33.30 pi, rounded from a 60-bit fraction
  localparam glnw_pkg::q_t PI_FIX =
    glnw_pkg::q_t'((64'h3243F6A8885A308D + (64'd1 << 29)) >> 30);

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  glnw_pkg::glnw_in_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  glnw_pkg::glnw_out_t out_data_o;
  logic                cfg_we_i = 1'b0;
  logic                cfg_idx_i = 1'b0;
  logic [7:0]          cfg_wdata_i = '0;

  gauss_lobatto_node_weight dut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // bench copy of the two registers
  int unsigned iter_limit = 100;
  int unsigned tol_lsbs   = 16;

  glnw_pkg::glnw_out_t pending_pts[$];
  int          fail_count  = 0;
  int          hold_cycles = 0;  // long receiver hold-off, counted by the receiver
  bit          quiet       = 1'b0; // no idling on either side

  // ---------------------------------------------------------------------------
  // Fixed-point helpers: exact product/quotient, round half away, saturate
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] absu(glnw_pkg::q_t a);
    return a[63] ? (64'd0 - 64'(a)) : 64'(a);
  endfunction

  function automatic glnw_pkg::q_t s_add(glnw_pkg::q_t a, glnw_pkg::q_t b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(glnw_pkg::SAT_MAX)) return glnw_pkg::SAT_MAX;
    if (s < 65'(glnw_pkg::SAT_MIN)) return glnw_pkg::SAT_MIN;
    return glnw_pkg::q_t'(s);
  endfunction

  function automatic glnw_pkg::q_t s_sub(glnw_pkg::q_t a, glnw_pkg::q_t b);
    return s_add(a, (b == glnw_pkg::SAT_MIN) ? glnw_pkg::SAT_MAX : -b);
  endfunction

  function automatic glnw_pkg::q_t mul_div(glnw_pkg::q_t a, glnw_pkg::q_t b,
                                           glnw_pkg::q_t c);
    logic [127:0] prod, quo, rem;
    logic [63:0]  d;
    bit           neg;
    d = absu(c);
    if (d == 0) return '0;
    neg  = ((a < 0) != (b < 0)) != (c < 0);
    prod = {64'd0, absu(a)} * {64'd0, absu(b)};
    quo  = prod / d;
    rem  = prod % d;
    if (rem >= 128'(d) - rem) quo = quo + 1;
    if (!neg) return (quo > 128'h7FFF_FFFF_FFFF_FFFF) ? glnw_pkg::SAT_MAX : glnw_pkg::q_t'(quo);
    if (quo >= 128'h8000_0000_0000_0000) return glnw_pkg::SAT_MIN;
    return -glnw_pkg::q_t'(quo);
  endfunction

  function automatic glnw_pkg::q_t fmul(glnw_pkg::q_t a, glnw_pkg::q_t b);
    return mul_div(a, b, glnw_pkg::QONE);
  endfunction

  // P_m(x) and P_(m-1)(x) by the three-term recurrence
  function automatic void legendre(int m, glnw_pkg::q_t x, output glnw_pkg::q_t pm,
                                   output glnw_pkg::q_t pm1);
    glnw_pkg::q_t lo, hi, t, nx;
    lo = glnw_pkg::QONE;
    hi = x;
    for (int k = 2; k <= m; k++) begin
      t  = fmul(x, hi);
      nx = s_sub(mul_div(glnw_pkg::q_t'(2 * k - 1), t, glnw_pkg::q_t'(k)),
                 mul_div(glnw_pkg::q_t'(k - 1), lo, glnw_pkg::q_t'(k)));
      lo = hi;
      hi = nx;
    end
    pm  = hi;
    pm1 = lo;
  endfunction

  // Taylor cosine of pi*(h+1)/m, through the theta^28 term
  function automatic glnw_pkg::q_t seed_cos(int h, int m);
    glnw_pkg::q_t theta, th2, term, sum;
    theta = mul_div(PI_FIX, glnw_pkg::q_t'(h + 1), glnw_pkg::q_t'(m));
    th2   = fmul(theta, theta);
    term  = glnw_pkg::QONE;
    sum   = glnw_pkg::QONE;
    for (int k = 1; k <= 14; k++) begin
      term = mul_div(fmul(term, th2), 64'sd1, glnw_pkg::q_t'((2 * k - 1) * (2 * k)));
      term = (term == glnw_pkg::SAT_MIN) ? glnw_pkg::SAT_MAX : -term;
      sum  = s_add(sum, term);
    end
    return sum;
  endfunction

  // Newton refinement of one non-negative interior root, then its weight
  function automatic logic [2:0] newton_root(int n, int h, bit centre,
                                             output glnw_pkg::q_t root,
                                             output glnw_pkg::q_t wt);
    glnw_pkg::q_t pv, pp, resid, deriv, corr, den, w;
    bit           conv;
    root = seed_cos(h, n - 1);
    wt   = '0;
    conv = 1'b0;
    for (int unsigned it = 1; it <= iter_limit; it++) begin
      legendre(n - 1, root, pv, pp);
      resid = s_sub(fmul(root, pv), pp);
      deriv = mul_div(pv, glnw_pkg::q_t'(n), 64'sd1);
      if (deriv == 0) return glnw_pkg::ST_NOCONV;
      corr = mul_div(resid, glnw_pkg::QONE, deriv);
      root = s_sub(root, corr);
      if (root > glnw_pkg::QTWO) root = glnw_pkg::QTWO;
      if (root < -glnw_pkg::QTWO) root = -glnw_pkg::QTWO;
      if (absu(corr) <= 64'(tol_lsbs)) begin
        conv = 1'b1;
        break;
      end
    end
    if (!conv) return glnw_pkg::ST_NOCONV;
    if (centre) root = '0;
    if (root < 0 || root >= glnw_pkg::QONE || (!centre && root == 0))
      return glnw_pkg::ST_BADROOT;
    // recheck at the final root
    legendre(n - 1, root, pv, pp);
    resid = s_sub(fmul(root, pv), pp);
    deriv = mul_div(pv, glnw_pkg::q_t'(n), 64'sd1);
    if (deriv == 0) return glnw_pkg::ST_BADROOT;
    corr = mul_div(resid, glnw_pkg::QONE, deriv);
    if (absu(corr) > 64'(tol_lsbs)) return glnw_pkg::ST_BADROOT;
    den = mul_div(fmul(pv, pv), glnw_pkg::q_t'(n * (n - 1)), 64'sd1);
    if (den <= 0) return glnw_pkg::ST_BADROOT;
    w = mul_div(glnw_pkg::QTWO, glnw_pkg::QONE, den);
    if (w <= 0) return glnw_pkg::ST_BADROOT;
    if (w > glnw_pkg::QONE) w = glnw_pkg::QONE;
    wt = w;
    return glnw_pkg::ST_OK;
  endfunction

  function automatic glnw_pkg::glnw_out_t predict_point(glnw_pkg::glnw_in_t pt);
    glnw_pkg::glnw_out_t r;
    int                  e, idx, n, h;
    bit                  left;
    glnw_pkg::q_t        node, wt, root;
    logic [2:0]          st;
    r   = '0;
    e   = pt.exactness;
    idx = pt.pt_idx;
    if (e > int'(glnw_pkg::MAX_EXACT)) begin
      r.status = glnw_pkg::ST_RANGE;
      return r;
    end
    n = e / 2 + 2;
    r.point_count        = 8'(n);
    r.achieved_exactness = 8'(2 * n - 3);
    if (idx >= n) begin
      r.status = glnw_pkg::ST_INDEX;
      return r;
    end
    st = glnw_pkg::ST_OK;
    if (idx == 0 || idx == n - 1) begin
      node = (idx == 0) ? -glnw_pkg::QONE : glnw_pkg::QONE;
      wt   = mul_div(glnw_pkg::QTWO, 64'sd1, glnw_pkg::q_t'(n * (n - 1)));
    end else begin
      left = (idx - 1) < (n - 1) / 2;
      h    = left ? idx - 1 : n - 2 - idx;
      st   = newton_root(n, h, 2 * h == n - 3, root, wt);
      if (st != glnw_pkg::ST_OK) begin
        node = '0;
        wt   = '0;
      end else begin
        node = left ? -root : root;
      end
    end
    r.node   = node[31:0];
    r.weight = wt[30:0];
    r.status = st;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stall bursts, long hold-off, field checks at the falling edge
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string field, longint got, longint want);
    fail_count++;
    $display("MISMATCH %0t: %s got %0d want %0d", $realtime, field, got, want);
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_cycles--;
      end else if (quiet) begin
        out_stall_i <= 1'b0;
        stall_left = 0;
      end else if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else if ($urandom_range(9) == 0) begin
        out_stall_i <= 1'b1;
        stall_left = $urandom_range(7);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    glnw_pkg::glnw_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pts.size() == 0) begin
        report_mismatch("unexpected beat, status", out_data_o.status, -1);
      end else begin
        want = pending_pts.pop_front();
        if (out_data_o.node != want.node)
          report_mismatch("node", out_data_o.node, want.node);
        if (out_data_o.weight != want.weight)
          report_mismatch("weight", out_data_o.weight, want.weight);
        if (out_data_o.point_count != want.point_count)
          report_mismatch("point_count", out_data_o.point_count, want.point_count);
        if (out_data_o.achieved_exactness != want.achieved_exactness)
          report_mismatch("achieved_exactness", out_data_o.achieved_exactness,
                          want.achieved_exactness);
        if (out_data_o.status != want.status)
          report_mismatch("status", out_data_o.status, want.status);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Offers one beat; returns at the edge that takes it, valid still high, or after a random idle gap
  task automatic offer_point(glnw_pkg::glnw_in_t pt, bit typed, glnw_pkg::glnw_out_t want);
    in_valid_i <= 1'b1;
    in_data_i  <= pt;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    pending_pts.push_back(typed ? want : predict_point(pt));
    if (!quiet && $urandom_range(5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  // Idle the block: every result back, then a short settle
  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [7:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (idx == glnw_pkg::CFG_ITER_LIMIT) iter_limit = val & 8'h7F;
    else                                 tol_lsbs   = val;
  endtask

  task automatic end_cfg;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly small well-formed rules; some noise over the whole field range.
  // Big rules only land on cheap points so the run stays short.
  function automatic glnw_pkg::glnw_in_t pick_point();
    glnw_pkg::glnw_in_t pt;
    int                 e, idx, n;
    if ($urandom_range(9) < 2) begin
      e   = $urandom_range(255);
      idx = $urandom_range(127);
      if (e <= int'(glnw_pkg::MAX_EXACT) && e > 24 && idx > 0 && idx < e / 2 + 1) idx = 0;
    end else begin
      e   = $urandom_range(24);
      n   = e / 2 + 2;
      idx = $urandom_range(n - 1);
    end
    pt.exactness = 8'(e);
    pt.pt_idx    = 7'(idx);
    return pt;
  endfunction

  task automatic random_points(int count);
    for (int i = 0; i < count; i++) offer_point(pick_point(), 1'b0, '0);
  endtask

  typedef struct {
    glnw_pkg::glnw_in_t  pt;
    bit                  typed;
    glnw_pkg::glnw_out_t want;
  } dir_row_t;

  // node, weight, point_count, achieved_exactness, status
  dir_row_t directed_rows[] = '{
    // out of range: everything zero
    '{'{8'd254, 7'd0},   1'b1, '{32'sd0, 31'd0, 8'd0, 8'd0, glnw_pkg::ST_RANGE}},
    '{'{8'd255, 7'd127}, 1'b1, '{32'sd0, 31'd0, 8'd0, 8'd0, glnw_pkg::ST_RANGE}},
    // two-point rule: endpoints, weight one
    '{'{8'd0, 7'd0},     1'b1,
      '{-32'sd1073741824, 31'd1073741824, 8'd2, 8'd1, glnw_pkg::ST_OK}},
    '{'{8'd0, 7'd1},     1'b1,
      '{32'sd1073741824, 31'd1073741824, 8'd2, 8'd1, glnw_pkg::ST_OK}},
    '{'{8'd1, 7'd1},     1'b1,
      '{32'sd1073741824, 31'd1073741824, 8'd2, 8'd1, glnw_pkg::ST_OK}},
    // index beyond the rule
    '{'{8'd0, 7'd2},     1'b1, '{32'sd0, 31'd0, 8'd2, 8'd1, glnw_pkg::ST_INDEX}},
    '{'{8'd0, 7'd127},   1'b1, '{32'sd0, 31'd0, 8'd2, 8'd1, glnw_pkg::ST_INDEX}},
    // largest rule, endpoints: weight 2/(128*127)
    '{'{8'd253, 7'd0},   1'b1,
      '{-32'sd1073741824, 31'd132104, 8'd128, 8'd253, glnw_pkg::ST_OK}},
    '{'{8'd253, 7'd127}, 1'b1,
      '{32'sd1073741824, 31'd132104, 8'd128, 8'd253, glnw_pkg::ST_OK}},
    '{'{8'd252, 7'd127}, 1'b1,
      '{32'sd1073741824, 31'd132104, 8'd128, 8'd253, glnw_pkg::ST_OK}},
    // odd rules, centre forced to zero
    '{'{8'd2, 7'd1},     1'b0, '0},
    '{'{8'd6, 7'd2},     1'b0, '0},
    '{'{8'd22, 7'd6},    1'b0, '0},
    // interior points, left and mirrored right halves
    '{'{8'd4, 7'd1},     1'b0, '0},
    '{'{8'd4, 7'd2},     1'b0, '0},
    '{'{8'd5, 7'd2},     1'b0, '0},
    '{'{8'd10, 7'd1},    1'b0, '0},
    '{'{8'd10, 7'd5},    1'b0, '0},
    '{'{8'd24, 7'd3},    1'b0, '0},
    '{'{8'd24, 7'd12},   1'b0, '0},
    // one interior point of the largest rule
    '{'{8'd253, 7'd64},  1'b0, '0}
  };

  initial begin
    glnw_pkg::glnw_in_t pt;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset settings: directed table
    foreach (directed_rows[i])
      offer_point(directed_rows[i].pt, directed_rows[i].typed, directed_rows[i].want);

    // single Newton step, exact tolerance: mostly no convergence
    drain();
    write_cfg(glnw_pkg::CFG_ITER_LIMIT, 8'd1);
    write_cfg(glnw_pkg::CFG_TOLERANCE, 8'd0);
    end_cfg();
    random_points(40);

    // no steps at all: every interior point fails at once
    drain();
    write_cfg(glnw_pkg::CFG_ITER_LIMIT, 8'd0);
    write_cfg(glnw_pkg::CFG_TOLERANCE, 8'd255);
    end_cfg();
    random_points(40);

    // widest limits; receiver holds off while endpoints pile up
    drain();
    write_cfg(glnw_pkg::CFG_ITER_LIMIT, 8'd127);
    end_cfg();
    random_points(20);
    hold_cycles = 3000;
    for (int i = 0; i < 10; i++) begin
      pt.exactness = 8'($urandom_range(255));
      pt.pt_idx    = 7'd0;
      offer_point(pt, 1'b0, '0);
    end
    random_points(30);

    // middling settings, with one full pause half way
    drain();
    write_cfg(glnw_pkg::CFG_ITER_LIMIT, 8'd3);
    write_cfg(glnw_pkg::CFG_TOLERANCE, 8'd8);
    end_cfg();
    random_points(30);
    in_valid_i <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk_i);
    random_points(30);

    // back to reset values; the tail runs without idling
    drain();
    write_cfg(glnw_pkg::CFG_ITER_LIMIT, 8'd100);
    write_cfg(glnw_pkg::CFG_TOLERANCE, 8'd16);
    end_cfg();
    random_points(50);
    quiet = 1'b1;
    random_points(40);

    in_valid_i <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk_i);
    repeat (500) @(posedge clk_i);
    if (fail_count == 0 && pending_pts.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #200_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

### filelist.f
rtl/core/glnw_pkg.sv
rtl/core/glnw_muldiv.sv
rtl/core/gauss_lobatto_node_weight.sv
bench/tb_gauss_lobatto_node_weight.sv
